/* hdl/bpjw_pkg.sv */
// ============================================================================
// bpjw_pkg
// Shared constants and hash arithmetic for the bidirectional PJW string hash.
// ============================================================================
`default_nettype none

package bpjw_pkg;

    localparam int BASE_ROUNDS     = 42;
    localparam int MAX_WIDTH_SHIFT = 2;
    localparam int STORE_DEPTH     = BASE_ROUNDS << MAX_WIDTH_SHIFT;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int SHIFT_W         = 2;
    localparam int BYTE_W          = 8;
    localparam int HASH_W          = 32;
    localparam int COUNT_W         = 32;

    localparam logic [HASH_W-1:0] HASH_MASK = 32'h7fff_ffff;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SHIFT_W-1:0] shift_t;
    typedef logic [BYTE_W-1:0]  byte_t;

    function automatic hash_t sext8(input byte_t b);
        return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    // One PJW-style fold: h ^= (h << 4) + sext(b), keep 31 bits.
    function automatic hash_t fold(input hash_t h, input byte_t b);
        hash_t sum;
        sum = (h << 4) + sext8(b);
        return (h ^ sum) & HASH_MASK;
    endfunction

    function automatic shift_t clamp_shift(input shift_t s);
        return (s > shift_t'(MAX_WIDTH_SHIFT)) ? shift_t'(MAX_WIDTH_SHIFT) : s;
    endfunction

    // Round limit for a character width: (BASE_ROUNDS << shift) - 1.
    function automatic addr_t round_cap(input shift_t s);
        return addr_t'((BASE_ROUNDS << s) - 1);
    endfunction

    function automatic addr_t ring_inc(input addr_t p);
        return (p == addr_t'(STORE_DEPTH - 1)) ? '0 : addr_t'(p + 1'b1);
    endfunction

    function automatic addr_t ring_dec(input addr_t p);
        return (p == '0) ? addr_t'(STORE_DEPTH - 1) : addr_t'(p - 1'b1);
    endfunction

endpackage

`default_nettype wire

/* hdl/bpjw_ram.sv */
// ============================================================================
// bpjw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module bpjw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 168
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/bidirectional_pjw_string_hash.sv */
// ============================================================================
// bidirectional_pjw_string_hash
// Streaming PJW-style string hash that folds bytes from both ends of a string.
// ============================================================================
// Usage:
//   A string enters on the s_ channel one byte per transaction. s_tlast marks
//   its final byte. s_tuser carries the character width shift (sampled on the
//   first byte, clamped to 2) and an empty-string flag; an empty-string
//   transaction drops any string in progress and yields a hash of zero.
//   One hash per string leaves on the m_ channel.
//   Throughput: non-final bytes are taken one per cycle. After the final byte
//   the block reads one head byte and one tail byte per round from its two
//   byte RAMs and folds them one per cycle; R = min(n/2, (42 << shift) - 1)
//   rounds run (at most 167). The fold rate is set by the single hash adder
//   and the one read port of each RAM. A string with no round (empty or one
//   byte) skips the reads and goes straight to the output state.
//   Stalls: the result sits in an output register; bytes of the next string
//   keep flowing while it waits. A finished hash waits in the sequencer until
//   the output register frees, and no new byte is taken meanwhile.
//   Reset (aresetn low, synchronous) clears the length, ring write pointer
//   and output valid. The byte RAMs are not cleared: every entry a hash reads
//   was written earlier in the same string, so no clearing pass runs.
// ============================================================================
`default_nettype none

module bidirectional_pjw_string_hash
    import bpjw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    input  wire logic [2:0]  s_tuser,   // [1:0] width_shift, [2] empty_string
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] hash_value
);

    // Sequencer states
    localparam logic [2:0] S_LOAD   = 3'd0;  // take bytes, fill the RAMs
    localparam logic [2:0] S_READ   = 3'd1;  // first read of head/tail
    localparam logic [2:0] S_FOLD_H = 3'd2;  // fold head byte, issue next read
    localparam logic [2:0] S_FOLD_T = 3'd3;  // fold held tail byte
    localparam logic [2:0] S_OUT    = 3'd4;  // hand hash to output register

    logic [2:0] state_reg, state_next;
    count_t     count_reg, count_next;
    addr_t      ring_ptr_reg, ring_ptr_next;
    shift_t     shift_reg, shift_next;
    byte_t      first_reg, first_next;
    hash_t      acc_reg, acc_next;
    addr_t      rounds_reg, rounds_next;
    addr_t      head_ptr_reg, head_ptr_next;
    addr_t      tail_ptr_reg, tail_ptr_next;
    byte_t      tail_hold_reg, tail_hold_next;
    logic       m_valid_reg, m_valid_next;
    hash_t      m_data_reg, m_data_next;

    // Input fields
    byte_t  in_byte;
    logic   in_empty;
    shift_t in_shift;
    logic   s_fire;

    // Per-byte arithmetic
    count_t               count_inc;
    logic [COUNT_W-2:0]   half_len;
    shift_t               shift_eff;
    addr_t                cap;
    addr_t                rounds_calc;
    byte_t                seed_byte;

    // RAM ports
    logic  head_wr_en;
    logic  tail_wr_en;
    logic  rd_go;
    byte_t head_rd_data;
    byte_t tail_rd_data;

    assign in_byte  = s_tdata;
    assign in_shift = s_tuser[1:0];
    assign in_empty = s_tuser[2];

    assign s_tready = (state_reg == S_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign count_inc   = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign half_len    = count_inc[COUNT_W-1:1];
    assign shift_eff   = (count_reg == '0) ? clamp_shift(in_shift) : shift_reg;
    assign cap         = round_cap(shift_eff);
    assign rounds_calc = (half_len > (COUNT_W-1)'(cap)) ? cap : half_len[ADDR_W-1:0];
    assign seed_byte   = (count_reg == '0) ? in_byte : first_reg;

    // Store writes: head keeps the first bytes only, tail wraps forever.
    assign head_wr_en = s_fire && !in_empty && (count_reg < count_t'(STORE_DEPTH));
    assign tail_wr_en = s_fire && !in_empty;

    // Read the next round's pair; in FOLD_H only if another round follows.
    assign rd_go = (state_reg == S_READ) ||
                   ((state_reg == S_FOLD_H) && (rounds_reg != addr_t'(1)));

    bpjw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (in_byte),
        .rd_en   (rd_go),
        .rd_addr (head_ptr_reg),
        .rd_data (head_rd_data)
    );

    bpjw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_tail_ram (
        .aclk    (aclk),
        .wr_en   (tail_wr_en),
        .wr_addr (ring_ptr_reg),
        .wr_data (in_byte),
        .rd_en   (rd_go),
        .rd_addr (tail_ptr_reg),
        .rd_data (tail_rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ring_ptr_next  = ring_ptr_reg;
        shift_next     = shift_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        rounds_next    = rounds_reg;
        head_ptr_next  = head_ptr_reg;
        tail_ptr_next  = tail_ptr_reg;
        tail_hold_next = tail_hold_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        // Drain the output register on a completed result transaction.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Advance read pointers: head forward from index 1, tail backward
        // from the entry holding the final byte.
        if (rd_go) begin
            head_ptr_next = addr_t'(head_ptr_reg + 1'b1);
            tail_ptr_next = ring_dec(tail_ptr_reg);
        end

        case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (in_empty) begin
                        // drop any string in progress, emit zero
                        count_next    = '0;
                        ring_ptr_next = '0;
                        acc_next      = '0;
                        rounds_next   = '0;
                        state_next    = S_OUT;
                    end else begin
                        if (count_reg == '0) begin
                            shift_next = shift_eff;
                            first_next = in_byte;
                        end
                        if (s_tlast) begin
                            acc_next      = sext8(seed_byte) ^ count_inc;
                            rounds_next   = rounds_calc;
                            head_ptr_next = addr_t'(1);
                            tail_ptr_next = ring_ptr_reg;
                            count_next    = '0;
                            ring_ptr_next = '0;
                            state_next    = (rounds_calc == '0) ? S_OUT : S_READ;
                        end else begin
                            count_next    = count_inc;
                            ring_ptr_next = ring_inc(ring_ptr_reg);
                        end
                    end
                end
            end
            S_READ: begin
                state_next = S_FOLD_H;
            end
            S_FOLD_H: begin
                acc_next       = fold(acc_reg, head_rd_data);
                tail_hold_next = tail_rd_data;
                state_next     = S_FOLD_T;
            end
            S_FOLD_T: begin
                acc_next    = fold(acc_reg, tail_hold_reg);
                rounds_next = addr_t'(rounds_reg - 1'b1);
                state_next  = (rounds_reg == addr_t'(1)) ? S_OUT : S_FOLD_H;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = acc_reg;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            ring_ptr_reg <= '0;
            shift_reg    <= '0;
            acc_reg      <= '0;
            rounds_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ring_ptr_reg <= ring_ptr_next;
            shift_reg    <= shift_next;
            acc_reg      <= acc_next;
            rounds_reg   <= rounds_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg     <= first_next;
        head_ptr_reg  <= head_ptr_next;
        tail_ptr_reg  <= tail_ptr_next;
        tail_hold_reg <= tail_hold_next;
        m_data_reg    <= m_data_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An empty-string transaction goes straight to delivery with a zero hash.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_empty) |=> (state_reg == S_OUT) && (acc_reg == '0))
        else $error("empty string did not produce a zero hash");

    // A one-byte string runs no round: the hash is sext(byte) ^ 1.
    a_single_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !in_empty && s_tlast && (count_reg == '0))
        |=> (state_reg == S_OUT) && (acc_reg == (sext8($past(in_byte)) ^ hash_t'(1))))
        else $error("single-byte hash wrong");

    // The round count stays inside the store depth during hashing; the head
    // pointer may step one past the last entry once the final read is issued.
    a_rounds_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_READ) || (state_reg == S_FOLD_H) || (state_reg == S_FOLD_T))
        |-> (rounds_reg != '0) && (rounds_reg < addr_t'(STORE_DEPTH))
            && (head_ptr_reg <= addr_t'(STORE_DEPTH)))
        else $error("round counter or head pointer out of range");

    // A taken result with nothing ready to replace it clears the output.
    a_out_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_tready && (state_reg != S_OUT)) |=> !m_valid_reg)
        else $error("output register did not drain");

    // Every folded value keeps bit 31 clear.
    a_fold_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == S_FOLD_T) && aresetn && $past(aresetn) |-> !acc_reg[31])
        else $error("hash accumulator bit 31 set after a fold");

endmodule

`default_nettype wire

/* test/bidirectional_pjw_string_hash_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// bidirectional_pjw_string_hash_tb
// Self-checking bench: streams strings into the hash block byte by byte with
// random gaps on both channels and checks every hash against a predictor.
// ============================================================================

module bidirectional_pjw_string_hash_tb;

    import bpjw_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no transaction at all
    localparam int DRAIN_CYCLES = 400;   // covers hashing of the longest string
    localparam int RANDOM_ITEMS = 550;

    // ------------------------------------------------------------------------
    // Hash scoreboard: mirrors the head store, the tail ring and the length
    // counter, and queues the hash each final byte or empty flag produces.
    // ------------------------------------------------------------------------
    class pjw_hash_scoreboard;
        byte_t  head_bytes[STORE_DEPTH];
        byte_t  tail_bytes[STORE_DEPTH];
        count_t byte_len;
        shift_t char_shift;
        int     ring_wr;
        hash_t  hash_queue[$];
        int     errors;

        function new();
            byte_len   = '0;
            char_shift = '0;
            ring_wr    = 0;
            errors     = 0;
        endfunction

        function hash_t widen(byte_t b);
            return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
        endfunction

        function hash_t mix(hash_t h, byte_t b);
            hash_t t;
            t = (h << 4) + widen(b);
            return (h ^ t) & HASH_MASK;
        endfunction

        // Note one accepted input transaction.
        function void note_byte(byte_t data, bit last, shift_t sh, bit empty);
            count_t rounds;
            count_t cap;
            int     head_idx;
            int     tail_idx;
            hash_t  h;
            if (empty) begin
                byte_len = '0;
                ring_wr  = 0;
                hash_queue.push_back('0);
                return;
            end
            if (byte_len == 0)
                char_shift = (sh > shift_t'(MAX_WIDTH_SHIFT)) ? shift_t'(MAX_WIDTH_SHIFT) : sh;
            if (byte_len < STORE_DEPTH)
                head_bytes[byte_len] = data;
            tail_bytes[ring_wr] = data;
            ring_wr = (ring_wr == STORE_DEPTH - 1) ? 0 : ring_wr + 1;
            if (byte_len != '1)
                byte_len++;
            if (!last)
                return;
            cap    = count_t'((BASE_ROUNDS << char_shift) - 1);
            rounds = byte_len >> 1;
            if (rounds > cap)
                rounds = cap;
            h = widen(head_bytes[0]) ^ byte_len;
            for (int k = 0; k < int'(rounds); k++) begin
                head_idx = (1 + k >= STORE_DEPTH) ? STORE_DEPTH - 1 : 1 + k;
                tail_idx = (ring_wr + STORE_DEPTH - 1 - k) % STORE_DEPTH;
                h = mix(h, head_bytes[head_idx]);
                h = mix(h, tail_bytes[tail_idx]);
            end
            hash_queue.push_back(h);
            byte_len = '0;
            ring_wr  = 0;
        endfunction

        // Check one accepted result transaction against the oldest hash.
        function void check_hash(hash_t actual);
            hash_t want;
            if (hash_queue.size() == 0) begin
                $error("hash_value: none expected, actual %h", actual);
                errors++;
                return;
            end
            want = hash_queue.pop_front();
            if (actual !== want) begin
                $error("hash_value: expected %h, actual %h", want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return hash_queue.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0; // last_byte
    logic [2:0]  s_tuser  = '0;   // [1:0] width_shift, [2] empty_string
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] hash_value

    pjw_hash_scoreboard sb;
    int  items_sent;
    bit  send_calm;   // stretch with no sender gaps
    bit  recv_calm;   // stretch with no receiver stalls

    bidirectional_pjw_string_hash u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Input driver. Called at a falling edge; returns at a falling edge.
    // Hold tvalid high across back-to-back transactions, drop it only when a
    // gap is drawn.
    // ------------------------------------------------------------------------
    task automatic send_item(byte_t data, bit last, shift_t sh, bit empty);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        s_tuser  <= {empty, sh};
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(data, last, sh, empty);
        items_sent++;
        @(negedge aclk);
    endtask

    // Send a well-formed string of len bytes; later bytes carry a random shift
    // that the block must ignore.
    task automatic send_string(int len, shift_t first_sh);
        for (int i = 0; i < len; i++)
            send_item(byte_t'($urandom), i == len - 1,
                      (i == 0) ? first_sh : shift_t'($urandom_range(0, 3)), 1'b0);
        if ($urandom_range(0, 9) == 0)
            send_calm = !send_calm;
    endtask

    // Empty flag with random other fields.
    task automatic send_empty();
        send_item(byte_t'($urandom), bit'($urandom), shift_t'($urandom_range(0, 3)), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: stall tready at random, check each accepted hash.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = recv_calm ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_hash(m_tdata);
            if ($urandom_range(0, 19) == 0)
                recv_calm = !recv_calm;
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: abort with FAIL when no transaction moves on either channel until IDLE_LIMIT is reached.
    // ------------------------------------------------------------------------
    initial begin
        int idle;
        idle = 0;
        @(posedge aresetn);
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed strings, random strings, drain.
    // ------------------------------------------------------------------------
    initial begin
        int  r;
        int  len;
        bit  long_sent;
        sb         = new();
        items_sent = 0;
        send_calm  = 1'b0;
        recv_calm  = 1'b0;
        long_sent  = 1'b0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty strings: result is zero whatever the other fields hold.
        send_item(8'hFF, 1'b1, 2'd3, 1'b1);
        send_item(8'h00, 1'b0, 2'd0, 1'b1);
        // One-byte strings: no round runs, sign of the byte reaches bit 31.
        send_item(8'h80, 1'b1, 2'd0, 1'b0);
        send_item(8'h7F, 1'b1, 2'd3, 1'b0);   // shift above range, clamped
        send_item(8'h00, 1'b1, 2'd2, 1'b0);
        send_item(8'hFF, 1'b1, 2'd1, 1'b0);
        // Two and three bytes: one round from both ends.
        send_item(8'h80, 1'b0, 2'd0, 1'b0);
        send_item(8'h7F, 1'b1, 2'd3, 1'b0);
        send_item(8'hFF, 1'b0, 2'd2, 1'b0);
        send_item(8'h00, 1'b0, 2'd1, 1'b0);
        send_item(8'h80, 1'b1, 2'd0, 1'b0);
        // String in progress dropped by an empty flag.
        send_item(8'h12, 1'b0, 2'd1, 1'b0);
        send_item(8'h34, 1'b0, 2'd0, 1'b0);
        send_item(8'hA5, 1'b0, 2'd3, 1'b0);
        send_item(8'h5A, 1'b1, 2'd2, 1'b1);
        // Shift changes after the first byte must be ignored.
        send_item(8'hC3, 1'b0, 2'd1, 1'b0);
        send_item(8'h3C, 1'b0, 2'd3, 1'b0);
        send_item(8'h01, 1'b0, 2'd0, 1'b0);
        send_item(8'hFE, 1'b0, 2'd2, 1'b0);
        send_item(8'h77, 1'b1, 2'd3, 1'b0);

        // Random part: mostly short well-formed strings, some longer ones
        // that hit the round cap, one that wraps the tail ring at the top cap,
        // plus empty noise and broken strings.
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (!long_sent && items_sent > 200) begin
                send_string($urandom_range(336, 360), 2'd2);
                long_sent = 1'b1;
            end else if (r < 8) begin
                send_empty();
            end else if (r < 14) begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_item(byte_t'($urandom), 1'b0, shift_t'($urandom_range(0, 3)), 1'b0);
                send_empty();
            end else if (r < 22) begin
                send_string($urandom_range(84, 110), 2'd0);
            end else if (r < 30) begin
                send_string($urandom_range(13, 60), shift_t'($urandom_range(0, 3)));
            end else begin
                send_string($urandom_range(1, 12), shift_t'($urandom_range(0, 3)));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
